/* hw/rtl/dafmt_pkg.sv */
`default_nettype none

package dafmt_pkg;

  // format codes carried in the op field
  localparam logic OpInteger  = 1'b0;
  localparam logic OpDistance = 1'b1;

  // smallest value that no longer fits in four decimal digits
  localparam logic [31:0] DigitLimit = 32'd10000;
  localparam int unsigned ValW = 14;

  // ascii characters used in the text
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiStar  = 8'h2a;
  localparam logic [7:0] AsciiDot   = 8'h2e;
  localparam logic [7:0] AsciiSpace = 8'h20;
  localparam logic [7:0] AsciiC     = 8'h63;
  localparam logic [7:0] AsciiM     = 8'h6d;

  // queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // input transaction
  typedef struct packed {
    logic        op;
    logic [31:0] value;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_t;

  // classified item handed from front to back; digits[3] is leftmost
  typedef struct packed {
    logic            op;
    logic            over;
    logic [3:0][3:0] digits;
  } entry_t;

  // queue status seen by the producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

/* hw/rtl/dafmt_front.sv */
`default_nettype none

module dafmt_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire dafmt_pkg::in_t    in_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output dafmt_pkg::entry_t      entry_o
);
  import dafmt_pkg::*;

  typedef enum logic [0:0] {FsIdle, FsConv} fstate_e;

  fstate_e          state_q;
  logic [1:0]       cnt_q;
  logic [ValW-1:0]  val_q;
  logic [11:0]      bcd_q;
  logic             op_q;
  logic             over_q;

  logic [26:0]      prod;
  logic [ValW-1:0]  quo;
  logic [ValW+2:0]  times10;
  logic [ValW-1:0]  rem;
  logic [3:0]       digit;
  logic             last_step;
  logic             accept;

  // one divide-by-ten step per cycle, reciprocal exact for values below 16384
  always_comb begin
    prod      = 27'(val_q) * 27'd6554;
    quo       = ValW'(prod[26:16]);
    times10   = {quo, 3'b000} + {2'b00, quo, 1'b0};
    rem       = val_q - times10[ValW-1:0];
    digit     = rem[3:0];
    last_step = (state_q == FsConv) && (cnt_q == 2'd3);
    push_o    = last_step && !full_i;
    busy      = !((state_q == FsIdle) || push_o);
    accept    = start && !busy;
  end

  // entry pushed on the last step, carrying the leftmost digit straight in
  assign entry_o.op     = op_q;
  assign entry_o.over   = over_q;
  assign entry_o.digits = {digit, bcd_q};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsIdle;
      cnt_q   <= 2'd0;
    end else if (accept) begin
      state_q <= FsConv;
      cnt_q   <= 2'd0;
    end else if (state_q == FsConv && !last_step) begin
      cnt_q   <= cnt_q + 2'd1;
    end else if (push_o) begin
      state_q <= FsIdle;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q  <= in_i.value[ValW-1:0];
      op_q   <= in_i.op;
      over_q <= (in_i.value >= DigitLimit);
    end else if (state_q == FsConv && !last_step) begin
      val_q  <= quo;
      bcd_q  <= {digit, bcd_q[11:4]};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dafmt_fifo.sv */
`default_nettype none

module dafmt_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire dafmt_pkg::entry_t    entry_i,
  input  wire logic                 pop_i,
  output dafmt_pkg::entry_t         head_o,
  output dafmt_pkg::fifo_status_t   status_o
);
  import dafmt_pkg::*;

  entry_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q;
  logic [FifoPtrW-1:0] rd_q;
  logic [FifoCntW-1:0] cnt_q;

  assign head_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == FifoCntW'(FifoDepth));
  assign status_o.empty = (cnt_q == '0);

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dafmt_back.sv */
`default_nettype none

module dafmt_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dafmt_pkg::entry_t      head_i,
  input  wire dafmt_pkg::fifo_status_t status_i,
  output logic                        pop_o,
  output logic                        strobe_o,
  output dafmt_pkg::out_t             out_o
);
  import dafmt_pkg::*;

  entry_t     entry_q;
  logic       have_q;
  logic [2:0] idx_q;
  logic       strobe_q;
  out_t       out_q;

  logic [7:0] cur_char;
  logic       is_last;

  // digit character, asterisk when out of range
  function automatic logic [7:0] dig_char(input logic over, input logic [3:0] d);
    dig_char = over ? AsciiStar : (AsciiZero | {4'b0000, d});
  endfunction

  // character at the current position
  always_comb begin
    cur_char = AsciiSpace;
    if (entry_q.op == OpDistance) begin
      unique case (idx_q)
        3'd0:    cur_char = dig_char(entry_q.over, entry_q.digits[3]);
        3'd1:    cur_char = AsciiDot;
        3'd2:    cur_char = dig_char(entry_q.over, entry_q.digits[2]);
        3'd3:    cur_char = dig_char(entry_q.over, entry_q.digits[1]);
        3'd4:    cur_char = dig_char(entry_q.over, entry_q.digits[0]);
        3'd5:    cur_char = AsciiSpace;
        3'd6:    cur_char = AsciiC;
        3'd7:    cur_char = AsciiM;
        default: cur_char = AsciiSpace;
      endcase
    end else begin
      // leading zeros blank, rightmost digit always shown
      unique case (idx_q)
        3'd0: cur_char = (!entry_q.over && entry_q.digits[3] == 4'd0) ? AsciiSpace
                         : dig_char(entry_q.over, entry_q.digits[3]);
        3'd1: cur_char = (!entry_q.over && entry_q.digits[3] == 4'd0
                          && entry_q.digits[2] == 4'd0) ? AsciiSpace
                         : dig_char(entry_q.over, entry_q.digits[2]);
        3'd2: cur_char = (!entry_q.over && entry_q.digits[3] == 4'd0
                          && entry_q.digits[2] == 4'd0 && entry_q.digits[1] == 4'd0)
                         ? AsciiSpace : dig_char(entry_q.over, entry_q.digits[1]);
        3'd3: cur_char = dig_char(entry_q.over, entry_q.digits[0]);
        default: cur_char = AsciiSpace;
      endcase
    end
    is_last = (idx_q == ((entry_q.op == OpDistance) ? 3'd7 : 3'd4));
    pop_o   = (!have_q || is_last) && !status_i.empty;
  end

  // character sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q   <= 1'b0;
      idx_q    <= 3'd0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= have_q;
      if (pop_o) begin
        have_q <= 1'b1;
        idx_q  <= 3'd0;
      end else if (have_q) begin
        idx_q <= idx_q + 3'd1;
        if (is_last) begin
          have_q <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      entry_q <= head_i;
    end
    out_q.char_out <= cur_char;
    out_q.last     <= is_last;
  end

  assign strobe_o = strobe_q;
  assign out_o    = out_q;

endmodule

`default_nettype wire

/* hw/rtl/decimal_ascii_formatter.sv */
// channel   signals               direction  transaction
// input     start, busy, in_i     in         accepted when start high and busy low
// result    strobe_o, out_o       out        one character per cycle with strobe_o high
//
// each value gives 5 characters (integer) or 8 characters (distance), one per cycle.
// the front converts a value one divide-by-ten step a cycle, then queues it once not full.
// the back emits characters back to back from a 2-entry queue.
// the sustained rate of values is set by the character output.
// busy is high while the front converts, until its push; results cannot be stalled.
// reset clears the sequencers and the queue; no item is held across reset.
`default_nettype none

module decimal_ascii_formatter (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire dafmt_pkg::in_t   in_i,
  output logic                  strobe_o,
  output dafmt_pkg::out_t       out_o
);
  import dafmt_pkg::*;

  logic         push;
  logic         pop;
  entry_t       entry;
  entry_t       head;
  fifo_status_t status;

  // conversion front
  dafmt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .full_i  (status.full),
    .push_o  (push),
    .entry_o (entry)
  );

  // queue between front and back
  dafmt_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  // character back end
  dafmt_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .status_i (status),
    .pop_o    (pop),
    .strobe_o (strobe_o),
    .out_o    (out_o)
  );

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && status.full))
    else $error("push into full queue");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && status.empty))
    else $error("pop from empty queue");

  // every text ends in a space or an m
  a_last_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && out_o.last) |-> (out_o.char_out == AsciiSpace || out_o.char_out == AsciiM))
    else $error("text ends in unexpected character");

  // an accepted transaction keeps busy high in the next cycle during conversion
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

endmodule

`default_nettype wire
